@@ design/wsfm_pkg.sv @@
`timescale 1ns / 1ps

package wsfm_pkg;

   localparam logic [31:0] LimitReset = 32'd1024;
   localparam logic [7:0]  MaskBit    = 8'h80;
   localparam logic [6:0]  Len16Code  = 7'd126;
   localparam logic [6:0]  Len64Code  = 7'd127;
   localparam logic [31:0] ShortLimit = 32'd126;

   // Item kinds carried on the request tuser bit.
   typedef enum logic [0:0] {
      KindStart   = 1'b0,
      KindPayload = 1'b1
   } kind_type;

   // Header format chosen for a start item.
   typedef enum logic [1:0] {
      HdrReject,
      HdrShort,
      HdrMedium,
      HdrLong
   } hdr_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  opcode;
      logic [31:0] payload_length;
      logic [31:0] mask_key;
      logic [7:0]  payload_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       error;
   } result_type;

   // Byte of a 32-bit word counted from the most significant end.
   function automatic logic [7:0] be_byte(input logic [31:0] word, input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = word[31:24];
         2'd1:    b = word[23:16];
         2'd2:    b = word[15:8];
         default: b = word[7:0];
      endcase
      return b;
   endfunction

endpackage

@@ design/wsfm_in_reg.sv @@
`timescale 1ns / 1ps

module wsfm_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  wsfm_pkg::item_type in_item,
   output logic               hold_valid,
   output wsfm_pkg::item_type hold_item,
   input  logic               pop
);
   import wsfm_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // A new item may enter when the register is empty or is emptied this cycle.
   assign in_ready = !valid_ff || pop;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

@@ design/wsfm_encoder.sv @@
`timescale 1ns / 1ps

module wsfm_encoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [31:0]          csr_data,
   input  logic                 in_valid,
   input  wsfm_pkg::item_type   in_item,
   output logic                 pop,
   input  logic                 out_ready,
   output logic                 res_valid,
   output wsfm_pkg::result_type res
);
   import wsfm_pkg::*;

   logic [31:0] limit_ff;
   logic        frame_open_ff, frame_open_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic [31:0] key_store_ff, key_store_in;
   logic [1:0]  key_index_ff, key_index_in;
   logic [3:0]  seq_ff, seq_in;

   hdr_type     cls;
   logic [3:0]  hdr_len;
   logic [3:0]  last_seq;
   logic [3:0]  key_pos;
   logic [3:0]  long_pos;
   logic [7:0]  long_byte;
   logic        item_done;
   logic        emit;
   logic [31:0] len;

   assign len  = in_item.payload_length;
   assign emit = in_valid && out_ready;

   // Header format and the sequence bounds of a start item.
   always_comb begin
      if (len > limit_ff) begin
         cls = HdrReject;
      end else if (len < ShortLimit) begin
         cls = HdrShort;
      end else if (len[31:16] == 16'd0) begin
         cls = HdrMedium;
      end else begin
         cls = HdrLong;
      end
      case (cls)
         HdrShort: begin
            hdr_len  = 4'd2;
            last_seq = 4'd5;
         end
         HdrMedium: begin
            hdr_len  = 4'd4;
            last_seq = 4'd7;
         end
         HdrLong: begin
            hdr_len  = 4'd10;
            last_seq = 4'd13;
         end
         default: begin
            hdr_len  = 4'd0;
            last_seq = 4'd0;
         end
      endcase
   end

   assign key_pos   = seq_ff - hdr_len;
   assign long_pos  = seq_ff - 4'd2;
   // The 64-bit length field has its upper four bytes at zero.
   assign long_byte = long_pos[2] ? be_byte(len, long_pos[1:0]) : 8'h00;

   // One result byte per cycle, while the result register can take it, for the item in the input register.
   always_comb begin
      res       = '0;
      item_done = 1'b1;
      if (in_item.kind == KindPayload) begin
         if (!frame_open_ff) begin
            res.last  = 1'b1;
            res.error = 1'b1;
         end else begin
            res.out_byte = in_item.payload_byte ^ be_byte(key_store_ff, key_index_ff);
            res.last     = (bytes_left_ff == 32'd1);
         end
      end else if (cls == HdrReject) begin
         res.last  = 1'b1;
         res.error = 1'b1;
      end else begin
         item_done = (seq_ff == last_seq);
         res.last  = item_done && (len == 32'd0);
         if (seq_ff == 4'd0) begin
            res.out_byte = MaskBit | {4'd0, in_item.opcode};
         end else if (seq_ff < hdr_len) begin
            case (cls)
               HdrShort: begin
                  res.out_byte = MaskBit | {1'b0, len[6:0]};
               end
               HdrMedium: begin
                  if (seq_ff == 4'd1) begin
                     res.out_byte = MaskBit | {1'b0, Len16Code};
                  end else if (seq_ff == 4'd2) begin
                     res.out_byte = len[15:8];
                  end else begin
                     res.out_byte = len[7:0];
                  end
               end
               HdrLong: begin
                  if (seq_ff == 4'd1) begin
                     res.out_byte = MaskBit | {1'b0, Len64Code};
                  end else begin
                     res.out_byte = long_byte;
                  end
               end
               default: begin
                  res.out_byte = 8'h00;
               end
            endcase
         end else begin
            res.out_byte = be_byte(in_item.mask_key, key_pos[1:0]);
         end
      end
   end

   assign res_valid = in_valid;
   assign pop       = emit && item_done;

   // Frame state moves only when an item has given all its results; the header sequence steps with each byte.
   always_comb begin
      frame_open_in = frame_open_ff;
      bytes_left_in = bytes_left_ff;
      key_store_in  = key_store_ff;
      key_index_in  = key_index_ff;
      seq_in        = seq_ff;
      if (emit) begin
         seq_in = item_done ? 4'd0 : seq_ff + 4'd1;
      end
      if (pop) begin
         if (in_item.kind == KindPayload) begin
            if (frame_open_ff) begin
               key_index_in  = key_index_ff + 2'd1;
               bytes_left_in = bytes_left_ff - 32'd1;
               frame_open_in = (bytes_left_ff != 32'd1);
            end
         end else begin
            key_index_in = 2'd0;
            if (cls == HdrReject) begin
               frame_open_in = 1'b0;
               bytes_left_in = 32'd0;
            end else begin
               key_store_in  = in_item.mask_key;
               frame_open_in = (len != 32'd0);
               bytes_left_in = len;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LimitReset;
         frame_open_ff <= 1'b0;
         bytes_left_ff <= 32'd0;
         key_store_ff  <= 32'd0;
         key_index_ff  <= 2'd0;
         seq_ff        <= 4'd0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_data;
         end
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
         key_store_ff  <= key_store_in;
         key_index_ff  <= key_index_in;
         seq_ff        <= seq_in;
      end
   end

`ifndef NO_ASSERTIONS
   // A start item in mid-header must still be held in the input register.
   a_seq_held: assert property (@(posedge clock) disable iff (reset)
      (seq_ff != 4'd0) |-> (in_valid && in_item.kind == KindStart))
      else $error("header sequence running without a held start item");

   // A frame is open exactly while payload bytes remain.
   a_open_count: assert property (@(posedge clock) disable iff (reset)
      frame_open_ff == (bytes_left_ff != 32'd0))
      else $error("frame_open disagrees with bytes_left");

   // The final payload byte closes the frame.
   a_close: assert property (@(posedge clock) disable iff (reset)
      (pop && in_item.kind == KindPayload && bytes_left_ff == 32'd1) |=> !frame_open_ff)
      else $error("frame left open after its final byte");

   // Each masked payload byte advances the key position by one.
   a_key_step: assert property (@(posedge clock) disable iff (reset)
      (pop && in_item.kind == KindPayload && frame_open_ff)
         |=> (key_index_ff == 2'($past(key_index_ff) + 2'd1)))
      else $error("key index did not advance");
`endif

endmodule

@@ design/wsfm_out_reg.sv @@
`timescale 1ns / 1ps

module wsfm_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  wsfm_pkg::result_type res,
   output logic                 res_ready,
   output logic                 out_valid,
   output wsfm_pkg::result_type out_res,
   input  logic                 out_ready
);
   import wsfm_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   // The register takes a new result when empty or when its content leaves.
   assign res_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (res_ready) begin
         valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         res_ff <= res;
      end
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;

endmodule

@@ design/websocket_frame_masker.sv @@
`timescale 1ns / 1ps

// Masked WebSocket client frame encoder.
// The req_ channel takes items: tuser 0 is a frame start carrying opcode, payload length and
// masking key; tuser 1 is one raw payload byte. The rsp_ channel delivers frame bytes in order:
// header, the four key bytes, then each payload byte XORed with its key byte. tlast marks the
// final byte of a frame or an error transfer, and tuser flags an error (length over the limit,
// or a payload byte with no open frame), which comes as a single zero byte.
// The csr_ channel writes the payload length limit; it is always ready and should only be
// written while no item is in flight.
// The first result of an item passes through the input register and then the result
// register before it is offered. Payload bytes flow at one per cycle while rsp_tready stays
// high. A start item emits 6, 8 or 14 bytes on the single output byte path (short, 16-bit
// or 64-bit length form) and 1 byte when rejected; the request channel stalls while its
// header and key bytes are emitted.
// A result register sits between the encoder and rsp_, so a new item is accepted while a
// finished byte waits; when rsp_tready is low both registers fill and req_tready drops.
// Reset clears both registers, closes any open frame and loads the limit with 1024.
module websocket_frame_masker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] opcode, [35:4] payload_length, [67:36] mask_key, [75:68] payload_byte, rest zero
   input  logic [79:0] req_tdata,
   // [0] kind
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // [0] error
   output logic [0:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   import wsfm_pkg::*;

   item_type   req_item;
   item_type   hold_item;
   logic       hold_valid;
   logic       pop;
   logic       res_valid;
   logic       res_ready;
   result_type res;
   result_type out_res;

   // Unpack the request transfer into the item fields.
   assign req_item.kind           = kind_type'(req_tuser[0]);
   assign req_item.opcode         = req_tdata[3:0];
   assign req_item.payload_length = req_tdata[35:4];
   assign req_item.mask_key       = req_tdata[67:36];
   assign req_item.payload_byte   = req_tdata[75:68];

   // The limit register takes a write in any cycle.
   assign csr_ready = 1'b1;

   wsfm_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .hold_valid (hold_valid),
      .hold_item  (hold_item),
      .pop        (pop)
   );

   wsfm_encoder u_encoder (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_valid),
      .csr_data  (csr_data),
      .in_valid  (hold_valid),
      .in_item   (hold_item),
      .pop       (pop),
      .out_ready (res_ready),
      .res_valid (res_valid),
      .res       (res)
   );

   wsfm_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready),
      .out_valid (rsp_tvalid),
      .out_res   (out_res),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata    = out_res.out_byte;
   assign rsp_tlast    = out_res.last;
   assign rsp_tuser[0] = out_res.error;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the masked WebSocket client frame encoder.
//
// A directed script runs first. It covers a stray payload byte after reset, empty and
// over-limit frames, the three length forms at their boundaries, key byte rotation across
// more than four payload bytes, and a frame that a new start cuts short. It also sets the
// limit to both extremes. Random phases follow, one limit setting each. Most of their
// traffic is well-formed: a start, then some or all of that frame's payload bytes. The rest
// is stray payload bytes, over-limit starts and frames cut short by the next start. Both
// channels insert random idle and stall cycles, except in one phase that runs at full rate.
// Every result transfer is checked against an in-bench frame encoder model.
module tb;
   import wsfm_pkg::*;

   localparam int unsigned CycleLimit    = 300_000;
   localparam int unsigned ItemsPerPhase = 15;
   localparam int unsigned SettleCycles  = 16;

   // A script row either sends one item or rewrites the length limit.
   typedef enum logic {
      RowItem,
      RowLimit
   } row_op_type;

   typedef struct {
      row_op_type op;
      item_type   it;
      bit         lone_error;   // expected result is a single error transfer
   } script_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [3:0] opcode, [35:4] payload_length, [67:36] mask_key, [75:68] payload_byte, rest zero
   logic [79:0] req_tdata  = '0;
   // [0] kind
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [7:0] out_byte
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   // [0] error
   logic [0:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data   = '0;

   // Encoder model state. The limit copy is updated when a write is accepted.
   logic        enc_open      = 1'b0;
   logic [31:0] enc_remaining = '0;
   logic [31:0] enc_key       = '0;
   logic [1:0]  enc_phase     = '0;
   logic [31:0] enc_limit     = LimitReset;

   // Frame bytes predicted but not yet seen on the result channel, oldest first.
   result_type  bytes_due[$];

   int unsigned mismatches   = 0;
   int unsigned checked      = 0;
   int unsigned items_sent   = 0;
   int unsigned starts_sent  = 0;
   int unsigned bytes_sent   = 0;
   int unsigned limit_writes = 0;

   // When set, neither side inserts idle or stall cycles.
   bit          quiet_links  = 1'b0;

   websocket_frame_masker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("MISMATCH at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   function automatic void due_byte(input logic [7:0] b, input logic lst, input logic err);
      result_type r;
      r.out_byte = b;
      r.last     = lst;
      r.error    = err;
      bytes_due.push_back(r);
   endfunction

   // Appends the frame bytes that one accepted item produces and advances the model state.
   function automatic void encode_item(input item_type it);
      logic [31:0] len;
      logic [7:0]  kb;
      len = it.payload_length;
      if (it.kind == KindPayload) begin
         if (!enc_open) begin
            // A payload byte with no open frame is an error, and the state stays as it is.
            due_byte(8'h00, 1'b1, 1'b1);
         end else begin
            kb = enc_key[8 * (3 - int'(enc_phase)) +: 8];
            enc_phase     = enc_phase + 2'd1;
            enc_remaining = enc_remaining - 32'd1;
            enc_open      = (enc_remaining != 32'd0);
            due_byte(it.payload_byte ^ kb, enc_remaining == 32'd0, 1'b0);
         end
         return;
      end
      // A start abandons any unfinished frame without a result.
      enc_open      = 1'b0;
      enc_remaining = '0;
      enc_phase     = '0;
      if (len > enc_limit) begin
         due_byte(8'h00, 1'b1, 1'b1);
         return;
      end
      due_byte(MaskBit | {4'h0, it.opcode}, 1'b0, 1'b0);
      if (len < ShortLimit) begin
         due_byte(MaskBit | len[7:0], 1'b0, 1'b0);
      end else if (len < 32'd65536) begin
         due_byte(MaskBit | {1'b0, Len16Code}, 1'b0, 1'b0);
         due_byte(len[15:8], 1'b0, 1'b0);
         due_byte(len[7:0], 1'b0, 1'b0);
      end else begin
         // The 64-bit length form always has its upper four bytes zero.
         due_byte(MaskBit | {1'b0, Len64Code}, 1'b0, 1'b0);
         repeat (4) due_byte(8'h00, 1'b0, 1'b0);
         due_byte(len[31:24], 1'b0, 1'b0);
         due_byte(len[23:16], 1'b0, 1'b0);
         due_byte(len[15:8], 1'b0, 1'b0);
         due_byte(len[7:0], 1'b0, 1'b0);
      end
      // An empty frame ends on the last key byte.
      for (int i = 0; i < 4; i++) begin
         due_byte(it.mask_key[8 * (3 - i) +: 8], (i == 3) && (len == 32'd0), 1'b0);
      end
      enc_key = it.mask_key;
      if (len != 32'd0) begin
         enc_open      = 1'b1;
         enc_remaining = len;
      end
   endfunction

   function automatic item_type random_item(input kind_type k);
      item_type it;
      // Fields that the item kind does not use still carry random bits.
      it.kind           = k;
      it.opcode         = 4'($urandom);
      it.payload_length = $urandom;
      it.mask_key       = $urandom;
      it.payload_byte   = 8'($urandom);
      return it;
   endfunction

   function automatic script_row_type make_row(input row_op_type op, input kind_type k,
                                               input logic [3:0] opc, input logic [31:0] len,
                                               input logic [31:0] key, input logic [7:0] pb,
                                               input bit lone_error);
      script_row_type row;
      row.op                = op;
      row.it.kind           = k;
      row.it.opcode         = opc;
      row.it.payload_length = len;
      row.it.mask_key       = key;
      row.it.payload_byte   = pb;
      row.lone_error        = lone_error;
      return row;
   endfunction

   // Offers one item after a random gap and holds it until the transfer. The prediction is
   // made right at the accepting edge, before any result of the item can come back. Where
   // the script types the answer in, that lone error transfer replaces the model's output.
   task automatic send_item(input item_type it, input bit lone_error);
      int unsigned gap;
      int unsigned held;
      result_type  err_result;
      gap = quiet_links ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, it.payload_byte, it.mask_key, it.payload_length, it.opcode};
      req_tuser  <= it.kind;
      do @(posedge clock); while (!req_tready);
      held = bytes_due.size();
      encode_item(it);
      if (lone_error) begin
         err_result.out_byte = 8'h00;
         err_result.last     = 1'b1;
         err_result.error    = 1'b1;
         while (bytes_due.size() > held) void'(bytes_due.pop_back());
         bytes_due.push_back(err_result);
      end
      items_sent++;
      if (it.kind == KindStart) begin
         starts_sent++;
      end else begin
         bytes_sent++;
      end
   endtask

   // Stops offering items and waits until every predicted byte has been checked, then lets
   // the encoder settle so that it is truly idle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (bytes_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      enc_limit = value;
      limit_writes++;
   endtask

   // Result side: a random stall before each transfer, then the transferred byte is compared
   // field by field with the oldest prediction.
   initial begin : result_sink
      int unsigned stall;
      result_type  want;
      wait (!reset);
      forever begin
         stall = quiet_links ? 0 : $urandom_range(0, 12);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         checked++;
         if (bytes_due.size() == 0) begin
            report_mismatch("transfer with nothing expected, out_byte", 32'(rsp_tdata),
                            32'd0);
         end else begin
            want = bytes_due.pop_front();
            if (rsp_tdata !== want.out_byte) begin
               report_mismatch("out_byte", 32'(rsp_tdata), 32'(want.out_byte));
            end
            if (rsp_tlast !== want.last) begin
               report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
            end
            if (rsp_tuser[0] !== want.error) begin
               report_mismatch("error", 32'(rsp_tuser[0]), 32'(want.error));
            end
         end
      end
   end

   initial begin : watchdog
      repeat (CycleLimit) @(posedge clock);
      $display("Timeout after %0d cycles with %0d frame bytes still expected.",
               CycleLimit, bytes_due.size());
      $display("websocket_frame_masker verification failed");
      $finish;
   end

   initial begin : stimulus
      script_row_type script[$];
      item_type       it;
      logic [31:0]    len;
      logic [31:0]    phase_limits[5];
      int unsigned    phase_start;
      int unsigned    burst;
      int unsigned    roll;
      bit             paused;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed script. The limit is still at its reset value of 1024 here.
      script.push_back(make_row(RowItem,  KindPayload, 4'h0, 32'd0,       32'h0000_0000, 8'hFF, 1));
      script.push_back(make_row(RowItem,  KindStart,   4'h0, 32'd0,       32'h0000_0000, 8'h00, 0));
      script.push_back(make_row(RowItem,  KindStart,   4'hF, 32'd1025,    32'hFFFF_FFFF, 8'h00, 1));
      script.push_back(make_row(RowItem,  KindStart,   4'h1, 32'd3,       32'hFFFF_FFFF, 8'h00, 0));
      script.push_back(make_row(RowItem,  KindPayload, 4'h0, 32'd0,       32'h0000_0000, 8'h00, 0));
      script.push_back(make_row(RowItem,  KindPayload, 4'h0, 32'd0,       32'h0000_0000, 8'hFF, 0));
      script.push_back(make_row(RowItem,  KindPayload, 4'h0, 32'd0,       32'h0000_0000, 8'hA5, 0));
      script.push_back(make_row(RowItem,  KindPayload, 4'h0, 32'd0,       32'h0000_0000, 8'h5A, 1));
      script.push_back(make_row(RowItem,  KindStart,   4'h2, 32'd125,     32'h1234_5678, 8'h00, 0));
      script.push_back(make_row(RowItem,  KindPayload, 4'h0, 32'd0,       32'h0000_0000, 8'hC3, 0));
      // This start cuts the 125-byte frame short.
      script.push_back(make_row(RowItem,  KindStart,   4'h8, 32'd126,     32'hDEAD_BEEF, 8'h00, 0));
      script.push_back(make_row(RowItem,  KindPayload, 4'h0, 32'd0,       32'h0000_0000, 8'h3C, 0));
      script.push_back(make_row(RowItem,  KindStart,   4'h9, 32'd1024,    32'h0000_0000, 8'h00, 0));
      // Five payload bytes make the key byte index wrap around.
      script.push_back(make_row(RowItem,  KindStart,   4'hA, 32'd5,       32'hA5A5_A5A5, 8'h00, 0));
      script.push_back(make_row(RowItem,  KindPayload, 4'h0, 32'd0,       32'h0000_0000, 8'h01, 0));
      script.push_back(make_row(RowItem,  KindPayload, 4'h0, 32'd0,       32'h0000_0000, 8'h02, 0));
      script.push_back(make_row(RowItem,  KindPayload, 4'h0, 32'd0,       32'h0000_0000, 8'h03, 0));
      script.push_back(make_row(RowItem,  KindPayload, 4'h0, 32'd0,       32'h0000_0000, 8'h04, 0));
      script.push_back(make_row(RowItem,  KindPayload, 4'h0, 32'd0,       32'h0000_0000, 8'h05, 0));
      // Open the limit fully to reach the 16-bit upper edge and the 64-bit form.
      script.push_back(make_row(RowLimit, KindStart,   4'h0, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 0));
      script.push_back(make_row(RowItem,  KindStart,   4'h1, 32'd65535,   32'h0F0F_0F0F, 8'h00, 0));
      script.push_back(make_row(RowItem,  KindStart,   4'h2, 32'd65536,   32'hF0F0_F0F0, 8'h00, 0));
      script.push_back(make_row(RowItem,  KindStart,   4'hF, 32'hFFFF_FFFF, 32'h0102_0304, 8'h00, 0));
      script.push_back(make_row(RowItem,  KindPayload, 4'h0, 32'd0,       32'h0000_0000, 8'h80, 0));
      script.push_back(make_row(RowItem,  KindPayload, 4'h0, 32'd0,       32'h0000_0000, 8'h7F, 0));
      // With a zero limit only empty frames pass.
      script.push_back(make_row(RowLimit, KindStart,   4'h0, 32'd0,       32'h0000_0000, 8'h00, 0));
      script.push_back(make_row(RowItem,  KindStart,   4'h9, 32'd0,       32'h89AB_CDEF, 8'h00, 0));
      script.push_back(make_row(RowItem,  KindStart,   4'h1, 32'd1,       32'h1111_1111, 8'h00, 1));
      script.push_back(make_row(RowItem,  KindPayload, 4'h0, 32'd0,       32'h0000_0000, 8'h11, 1));

      foreach (script[r]) begin
         if (script[r].op == RowLimit) begin
            write_limit(script[r].it.payload_length);
         end else begin
            send_item(script[r].it, script[r].lone_error);
         end
      end

      // Random phases. Each one starts from an idle encoder with its own limit. The full-rate
      // phase keeps both channels busy with no gaps at all.
      phase_limits[0] = 32'hFFFF_FFFF;
      phase_limits[1] = 32'd0;
      phase_limits[2] = $urandom_range(1, 300);
      phase_limits[3] = 32'd65536;
      phase_limits[4] = LimitReset;
      paused = 1'b0;
      for (int ph = 0; ph < 5; ph++) begin
         write_limit(phase_limits[ph]);
         quiet_links = (ph == 2);
         phase_start = items_sent;
         while (items_sent - phase_start < ItemsPerPhase) begin
            if ($urandom_range(0, 9) == 0) begin
               // Stray byte. It is an error unless the previous frame is still open.
               send_item(random_item(KindPayload), 1'b0);
            end else begin
               roll = $urandom_range(0, 9);
               if (roll <= 5) begin
                  len = $urandom_range(0, 12);
               end else if (roll == 6) begin
                  len = $urandom_range(13, 125);
               end else if (roll == 7) begin
                  len = $urandom_range(126, 65535);
               end else if (roll == 8) begin
                  len = $urandom | 32'h0001_0000;
               end else begin
                  len = $urandom;
               end
               // Most over-limit starts are pulled within the limit. The others are rejected.
               if (len > enc_limit && $urandom_range(0, 2) != 0) begin
                  len = 32'({1'b0, len} % ({1'b0, enc_limit} + 33'd1));
               end
               it = random_item(KindStart);
               it.payload_length = len;
               send_item(it, 1'b0);
               // Short frames usually run to completion. Long ones get up to four bytes and are
               // then abandoned by the next start.
               burst = (len <= 32'd12 && $urandom_range(0, 4) != 0) ? int'(len)
                                                                   : $urandom_range(0, 4);
               repeat (burst) send_item(random_item(KindPayload), 1'b0);
            end
            // Once, in mid-phase, hold the sender back until the encoder has drained.
            if (ph == 3 && !paused && items_sent - phase_start >= ItemsPerPhase / 2) begin
               wait_idle();
               paused = 1'b1;
            end
         end
      end
      quiet_links = 1'b0;

      wait_idle();
      $display("Sent %0d items: %0d frame starts and %0d payload bytes, under %0d limit writes.",
               items_sent, starts_sent, bytes_sent, limit_writes);
      $display("Checked %0d result transfers; %0d mismatches found.", checked, mismatches);
      if (mismatches == 0) begin
         $display("websocket_frame_masker verification clean");
      end else begin
         $display("websocket_frame_masker verification failed");
      end
      $finish;
   end

endmodule
